### hw/rtl/htld_pkg.sv
// Package for the Huffman tree load and decode block.
// Holds sizes, command, kind and phase codes, and the structs shared by the modules.
package htld_pkg;

    localparam int INTERNAL_NODES = 256;
    localparam int NODE_BASE      = 256;
    localparam int NODE_W         = 9;
    localparam int CT_DEPTH       = 512;
    localparam int CT_AW          = $clog2(CT_DEPTH);
    localparam int ST_DEPTH       = INTERNAL_NODES;
    localparam int ST_AW          = (INTERNAL_NODES > 1) ? $clog2(INTERNAL_NODES) : 1;
    localparam int NCNT_W         = $clog2(INTERNAL_NODES + 1);
    localparam int LEN_W          = 24;
    localparam int BYTE_W         = 8;
    localparam int LEAF_CNT_W     = 3;

    localparam logic [1:0] CMD_RESTART = 2'd0;
    localparam logic [1:0] CMD_TREE    = 2'd1;
    localparam logic [1:0] CMD_DECODE  = 2'd2;

    localparam logic [1:0] KIND_BYTE     = 2'd0;
    localparam logic [1:0] KIND_LOADED   = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;

    localparam logic [1:0] PH_FLAG  = 2'd0;
    localparam logic [1:0] PH_LEAF  = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;
    localparam logic [1:0] PH_ERROR = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic       bit_req;
    } t_item;

    typedef struct packed {
        logic              ct_we;
        logic [CT_AW-1:0]  ct_waddr;
        logic [NODE_W-1:0] ct_wdata;
        logic [CT_AW-1:0]  ct_raddr;
        logic              st_we;
        logic [ST_AW-1:0]  st_waddr;
        logic [NODE_W-1:0] st_wdata;
        logic [ST_AW-1:0]  st_raddr;
    } t_mem_req;

    typedef struct packed {
        logic              valid;
        logic [1:0]        kind;
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_result;

endpackage

### hw/rtl/htld_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module htld_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/htld_engine.sv
// Tree loader and decode walker: state registers, memory addressing and result forming.
// Depends on htld_pkg; reads and writes the child table and load stack RAMs.
module htld_engine
    import htld_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_item             i_item,
    input  logic              i_commit,
    input  logic [LEN_W-1:0]  i_output_length,
    input  logic [NODE_W-1:0] i_ct_rdata,
    input  logic [NODE_W-1:0] i_st_rdata,
    output t_mem_req          o_req,
    output t_result           o_result
);

    logic [NCNT_W-1:0]     r_depth,     n_depth;
    logic [NCNT_W-1:0]     r_nodes,     n_nodes;
    logic [BYTE_W-1:0]     r_shift,     n_shift;
    logic [LEAF_CNT_W-1:0] r_leaf_cnt,  n_leaf_cnt;
    logic [1:0]            r_phase,     n_phase;
    logic [NODE_W-1:0]     r_root,      n_root;
    logic [NODE_W-1:0]     r_cur,       n_cur;
    logic [LEN_W-1:0]      r_count,     n_count;
    logic                  r_slot_root, n_slot_root;
    logic [BYTE_W-1:0]     r_slot_node, n_slot_node;
    logic                  r_slot_side, n_slot_side;

    logic              fill_en;
    logic [NODE_W-1:0] fill_v;
    logic [NODE_W-1:0] new_node;
    logic [BYTE_W-1:0] leaf_byte;
    logic [NCNT_W-1:0] depth_dec;
    logic [NODE_W-1:0] next_node;

    assign new_node  = NODE_W'(NODE_BASE) + NODE_W'(r_nodes);
    assign leaf_byte = {r_shift[BYTE_W-2:0], i_item.bit_req};
    assign depth_dec = r_depth - NCNT_W'(1);
    assign next_node = (r_root < NODE_W'(NODE_BASE)) ? r_root : i_ct_rdata;

    always_comb begin
        n_depth     = r_depth;
        n_nodes     = r_nodes;
        n_shift     = r_shift;
        n_leaf_cnt  = r_leaf_cnt;
        n_phase     = r_phase;
        n_root      = r_root;
        n_cur       = r_cur;
        n_count     = r_count;
        n_slot_root = r_slot_root;
        n_slot_node = r_slot_node;
        n_slot_side = r_slot_side;
        fill_en     = 1'b0;
        fill_v      = '0;
        o_result    = '0;
        o_req       = '0;
        o_req.ct_raddr = {i_item.bit_req, r_cur[BYTE_W-1:0]};
        o_req.st_raddr = depth_dec[ST_AW-1:0];

        unique case (i_item.command)
            CMD_RESTART: begin
                n_depth     = '0;
                n_nodes     = '0;
                n_shift     = '0;
                n_leaf_cnt  = '0;
                n_phase     = PH_FLAG;
                n_root      = '0;
                n_cur       = '0;
                n_count     = '0;
                n_slot_root = 1'b1;
                n_slot_node = '0;
                n_slot_side = 1'b0;
            end
            CMD_TREE: begin
                if (r_phase == PH_FLAG) begin
                    if (!i_item.bit_req) begin
                        n_phase    = PH_LEAF;
                        n_shift    = '0;
                        n_leaf_cnt = '0;
                    end else if (32'(r_nodes) >= INTERNAL_NODES) begin
                        n_phase         = PH_ERROR;
                        o_result.valid  = 1'b1;
                        o_result.kind   = KIND_OVERFLOW;
                    end else begin
                        n_nodes        = r_nodes + NCNT_W'(1);
                        fill_en        = 1'b1;
                        fill_v         = new_node;
                        o_req.st_we    = 1'b1;
                        o_req.st_waddr = r_depth[ST_AW-1:0];
                        o_req.st_wdata = new_node;
                        n_depth        = r_depth + NCNT_W'(1);
                        n_slot_root    = 1'b0;
                        n_slot_node    = new_node[BYTE_W-1:0];
                        n_slot_side    = 1'b0;
                    end
                end else if (r_phase == PH_LEAF) begin
                    n_shift    = leaf_byte;
                    n_leaf_cnt = r_leaf_cnt + LEAF_CNT_W'(1);
                    if (r_leaf_cnt == '1) begin
                        fill_en = 1'b1;
                        fill_v  = {1'b0, leaf_byte};
                        if (r_depth == '0) begin
                            n_phase        = PH_DONE;
                            n_cur          = r_slot_root ? {1'b0, leaf_byte} : r_root;
                            o_result.valid = 1'b1;
                            o_result.kind  = KIND_LOADED;
                        end else begin
                            n_depth     = depth_dec;
                            n_slot_root = 1'b0;
                            n_slot_node = i_st_rdata[BYTE_W-1:0];
                            n_slot_side = 1'b1;
                            n_phase     = PH_FLAG;
                        end
                    end
                end
            end
            CMD_DECODE: begin
                if (r_phase == PH_DONE && r_count < i_output_length) begin
                    if (next_node >= NODE_W'(NODE_BASE)) begin
                        n_cur = next_node;
                    end else begin
                        n_cur          = r_root;
                        n_count        = r_count + LEN_W'(1);
                        o_result.valid = 1'b1;
                        o_result.kind  = KIND_BYTE;
                        o_result.value = next_node[BYTE_W-1:0];
                        o_result.last  = (n_count == i_output_length);
                    end
                end
            end
            default: begin
            end
        endcase

        if (fill_en) begin
            if (r_slot_root) begin
                n_root = fill_v;
            end else begin
                o_req.ct_we    = 1'b1;
                o_req.ct_waddr = {r_slot_side, r_slot_node};
                o_req.ct_wdata = fill_v;
            end
        end

        o_req.ct_we    = o_req.ct_we & i_commit;
        o_req.st_we    = o_req.st_we & i_commit;
        o_result.valid = o_result.valid & i_commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_nodes     <= '0;
            r_shift     <= '0;
            r_leaf_cnt  <= '0;
            r_phase     <= PH_FLAG;
            r_root      <= '0;
            r_cur       <= '0;
            r_count     <= '0;
            r_slot_root <= 1'b1;
            r_slot_node <= '0;
            r_slot_side <= 1'b0;
        end else if (i_commit) begin
            r_depth     <= n_depth;
            r_nodes     <= n_nodes;
            r_shift     <= n_shift;
            r_leaf_cnt  <= n_leaf_cnt;
            r_phase     <= n_phase;
            r_root      <= n_root;
            r_cur       <= n_cur;
            r_count     <= n_count;
            r_slot_root <= n_slot_root;
            r_slot_node <= n_slot_node;
            r_slot_side <= n_slot_side;
        end
    end

endmodule

### hw/rtl/huffman_tree_load_and_decode.sv
// Top level of the Huffman tree load and decode block: handshakes, output register, memories.
// Depends on htld_pkg, htld_engine and htld_ram.
//
// Each input transaction carries one bit: restart, tree bit or decode bit. On an accepted
// transaction the child table is read at an address set by the bit and the current node,
// and the load stack at its top entry; the registered read data then completes the step
// and the memories are written. A new transaction is taken only after the last one has
// completed. A result waits in an output register; the block still takes a new transaction
// meanwhile and holds before completing a step only while that register is full and stalled.
// The output length register is written through its own channel, which is always ready.
module huffman_tree_load_and_decode
    import htld_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_command,
    input  logic              i_bit_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [1:0]        o_kind,
    output logic [BYTE_W-1:0] o_value,
    output logic              o_last,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [LEN_W-1:0]  i_cfg_data
);

    logic              r_busy;
    t_item             r_item;
    logic [LEN_W-1:0]  r_output_length;
    logic              r_out_valid;
    logic [1:0]        r_kind;
    logic [BYTE_W-1:0] r_value;
    logic              r_last;

    logic              accept;
    logic              commit;
    t_item             item_sel;
    t_mem_req          req;
    t_result           res;
    logic [NODE_W-1:0] ct_rdata;
    logic [NODE_W-1:0] st_rdata;

    assign o_in_stall  = r_busy;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !r_busy;
    assign commit      = r_busy && (!r_out_valid || !i_out_stall);
    assign item_sel    = r_busy ? r_item : t_item'{command: i_command, bit_req: i_bit_req};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_out_valid     <= 1'b0;
            r_output_length <= '0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (commit) begin
                r_busy <= 1'b0;
            end
            if (res.valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_output_length <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= item_sel;
        end
        if (res.valid) begin
            r_kind  <= res.kind;
            r_value <= res.value;
            r_last  <= res.last;
        end
    end

    htld_engine u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (item_sel),
        .i_commit        (commit),
        .i_output_length (r_output_length),
        .i_ct_rdata      (ct_rdata),
        .i_st_rdata      (st_rdata),
        .o_req           (req),
        .o_result        (res)
    );

    htld_ram #(
        .WIDTH (NODE_W),
        .DEPTH (CT_DEPTH)
    ) u_child_table (
        .i_clk   (i_clk),
        .i_we    (req.ct_we),
        .i_waddr (req.ct_waddr),
        .i_wdata (req.ct_wdata),
        .i_raddr (req.ct_raddr),
        .o_rdata (ct_rdata)
    );

    htld_ram #(
        .WIDTH (NODE_W),
        .DEPTH (ST_DEPTH)
    ) u_load_stack (
        .i_clk   (i_clk),
        .i_we    (req.st_we),
        .i_waddr (req.st_waddr),
        .i_wdata (req.st_wdata),
        .i_raddr (req.st_raddr),
        .o_rdata (st_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_value     = r_value;
    assign o_last      = r_last;

endmodule

### tb/tb_top.sv
// Self-checking testbench for huffman_tree_load_and_decode: tree loads, decode walks, restarts.
// A scoreboard class predicts every result from the accepted bits; depends on htld_pkg and the DUT top.
module tb_top;
    import htld_pkg::*;

    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         ITEM_TARGET = 1850;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } t_out_item;

    typedef enum {STALL_NONE, STALL_SPARSE, STALL_HALF, STALL_LONG} t_stall_mode;

    class decode_scoreboard;
        logic [8:0]  child_tbl [512];
        logic [8:0]  node_stack [256];
        logic [8:0]  depth;
        logic [9:0]  next_node;
        logic [7:0]  leaf_bits;
        int          leaf_cnt;
        logic [1:0]  phase;
        logic [8:0]  root;
        logic [8:0]  cur;
        logic [23:0] emitted;
        logic [23:0] out_len;
        bit          slot_root;
        logic [8:0]  slot_node;
        bit          slot_right;
        t_out_item   due[$];
        int          errors;

        function new();
            out_len = '0;
            errors  = 0;
            restart();
        endfunction

        function void restart();
            depth      = '0;
            next_node  = 10'd256;
            leaf_bits  = '0;
            leaf_cnt   = 0;
            phase      = PH_FLAG;
            root       = '0;
            cur        = '0;
            emitted    = '0;
            slot_root  = 1'b1;
            slot_node  = 9'd256;
            slot_right = 1'b0;
        endfunction

        function void fill_slot(logic [8:0] v);
            if (slot_root) begin
                root = v;
            end else begin
                child_tbl[{slot_right, slot_node[7:0]}] = v;
            end
        endfunction

        function void queue_result(logic [1:0] k, logic [7:0] v, logic l);
            t_out_item e;
            e.kind  = k;
            e.value = v;
            e.last  = l;
            due.push_back(e);
        endfunction

        function void take_bit(logic [1:0] cmd, logic b);
            logic [8:0] nxt;
            case (cmd)
                CMD_RESTART: restart();
                CMD_TREE: begin
                    if (phase == PH_FLAG) begin
                        if (!b) begin
                            phase     = PH_LEAF;
                            leaf_bits = '0;
                            leaf_cnt  = 0;
                        end else if (next_node - 10'd256 >= INTERNAL_NODES) begin
                            phase = PH_ERROR;
                            queue_result(KIND_OVERFLOW, 8'h00, 1'b0);
                        end else begin
                            nxt       = next_node[8:0];
                            next_node = next_node + 10'd1;
                            fill_slot(nxt);
                            node_stack[depth[7:0]] = nxt;
                            depth      = depth + 9'd1;
                            slot_root  = 1'b0;
                            slot_node  = nxt;
                            slot_right = 1'b0;
                        end
                    end else if (phase == PH_LEAF) begin
                        leaf_bits = {leaf_bits[6:0], b};
                        leaf_cnt++;
                        if (leaf_cnt == 8) begin
                            leaf_cnt = 0;
                            fill_slot({1'b0, leaf_bits});
                            if (depth == 0) begin
                                phase = PH_DONE;
                                cur   = root;
                                queue_result(KIND_LOADED, 8'h00, 1'b0);
                            end else begin
                                depth      = depth - 9'd1;
                                slot_root  = 1'b0;
                                slot_node  = node_stack[depth[7:0]];
                                slot_right = 1'b1;
                                phase      = PH_FLAG;
                            end
                        end
                    end
                end
                CMD_DECODE: begin
                    if (phase == PH_DONE && emitted < out_len) begin
                        if (!root[8]) begin
                            nxt = root;
                        end else begin
                            nxt = child_tbl[{b, cur[7:0]}];
                        end
                        if (root[8] && nxt[8]) begin
                            cur = nxt;
                        end else begin
                            if (root[8]) begin
                                cur = root;
                            end
                            emitted = emitted + 24'd1;
                            queue_result(KIND_BYTE, nxt[7:0], emitted == out_len);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void check_result(logic [1:0] k, logic [7:0] v, logic l);
            t_out_item e;
            if (due.size() == 0) begin
                report($sformatf("unexpected result: kind %0d value %02h last %0d", k, v, l));
                return;
            end
            e = due.pop_front();
            if (k !== e.kind || v !== e.value || l !== e.last) begin
                report($sformatf("mismatch: expected kind %0d value %02h last %0d, %s",
                                 e.kind, e.value, e.last,
                                 $sformatf("got kind %0d value %02h last %0d", k, v, l)));
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_command;
    logic              i_bit_req;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [1:0]        o_kind;
    logic [BYTE_W-1:0] o_value;
    logic              o_last;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [LEN_W-1:0]  i_cfg_data;

    decode_scoreboard sb;
    int               burst_left   = 0;
    int               useful_items = 0;
    int               cycles       = 0;
    int               stall_span   = 0;
    t_stall_mode      stall_mode   = STALL_NONE;

    huffman_tree_load_and_decode dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_bit_req   (i_bit_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_kind      (o_kind),
        .o_value     (o_value),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_span = $urandom_range(20, 200);
        end
        stall_span--;
        case (stall_mode)
            STALL_NONE:   i_out_stall <= 1'b0;
            STALL_SPARSE: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HALF:   i_out_stall <= 1'($urandom_range(0, 1));
            default:      i_out_stall <= (stall_span % 16) < 10;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_kind, o_value, o_last);
        end
    end

    task automatic send_bit(input logic [1:0] cmd, input logic b);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_bit_req  <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_bit(cmd, b);
    endtask

    task automatic send_leaf(input logic [7:0] leaf);
        send_bit(CMD_TREE, 1'b0);
        for (int i = 7; i >= 0; i--) begin
            send_bit(CMD_TREE, leaf[i]);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [23:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom_range(0, 24'hFFFFFF));
            default: return 24'($urandom_range(1, 60));
        endcase
    endfunction

    function automatic int pick_tree_size();
        case ($urandom_range(0, 9))
            0:       return 0;
            1, 2, 3, 4: return $urandom_range(1, 3);
            9:       return $urandom_range(16, 60);
            default: return $urandom_range(4, 15);
        endcase
    endfunction

    // pre-order: a leaf may only close the last open slot once every internal node is out
    task automatic send_tree(input int n_int);
        int open;
        int left;
        open = 1;
        left = n_int;
        while (open > 0) begin
            if ($urandom_range(0, 15) == 0) begin
                send_bit($urandom_range(0, 1) ? CMD_DECODE : CMD_SPARE,
                         1'($urandom_range(0, 1)));
            end
            if (left > 0 && (open == 1 || $urandom_range(0, 1))) begin
                send_bit(CMD_TREE, 1'b1);
                useful_items++;
                left--;
                open++;
            end else begin
                send_leaf(pick_byte());
                useful_items += 9;
                open--;
            end
        end
    endtask

    task automatic send_codes(input int n);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 19))
                0:       send_bit(CMD_TREE, 1'($urandom_range(0, 1)));
                1:       send_bit(CMD_SPARE, 1'($urandom_range(0, 1)));
                default: begin
                    send_bit(CMD_DECODE, 1'($urandom_range(0, 1)));
                    useful_items++;
                end
            endcase
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [23:0] len);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.out_len = len;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int phase_no;
        int sel;
        int n;
        sb          = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_command   = CMD_RESTART;
        i_bit_req   = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_length(24'd3);
        send_bit(CMD_DECODE, 1'b1);
        send_bit(CMD_SPARE, 1'b1);
        send_leaf(8'hFF);
        send_bit(CMD_DECODE, 1'b0);
        send_bit(CMD_DECODE, 1'b1);
        send_bit(CMD_DECODE, 1'b1);
        send_bit(CMD_DECODE, 1'b0);
        send_bit(CMD_TREE, 1'b1);
        send_bit(CMD_RESTART, 1'b0);
        send_bit(CMD_DECODE, 1'b0);

        phase_no = 0;
        while (useful_items < ITEM_TARGET) begin
            phase_no++;
            if (phase_no <= 2 || $urandom_range(0, 1)) begin
                settle();
                write_length(phase_no == 1 ? 24'hFFFFFF :
                             phase_no == 2 ? 24'd0 : pick_length());
            end
            send_bit(CMD_RESTART, 1'($urandom_range(0, 1)));
            sel = $urandom_range(0, 39);
            if (phase_no == 3 || sel == 0) begin
                repeat (INTERNAL_NODES + 1) send_bit(CMD_TREE, 1'b1);
                useful_items += INTERNAL_NODES + 1;
                repeat (5) send_bit(CMD_TREE, 1'($urandom_range(0, 1)));
                send_codes(10);
            end else if (sel <= 2) begin
                n = $urandom_range(1, 40);
                repeat (n) send_bit(CMD_TREE, 1'($urandom_range(0, 1)));
                useful_items += n;
                send_codes($urandom_range(1, 20));
            end else begin
                send_tree(pick_tree_size());
                send_codes($urandom_range(5, 80));
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
